[rtl/core/nro_pkg.sv]
// nro_pkg: shared types, register codes and helpers for the nv21 outline overlay
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package nro_pkg;

  // counter width for row and column positions
  localparam int COORD_BITS = 12;
  // signed width for geometry math, wide enough for every intermediate value
  localparam int GEO_W = ((COORD_BITS > 13) ? COORD_BITS : 13) + 4;

  // apb port widths
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH    = 3'd0;
  localparam reg_idx_t REG_FRAME_HEIGHT   = 3'd1;
  localparam reg_idx_t REG_RECT_LEFT      = 3'd2;
  localparam reg_idx_t REG_RECT_TOP       = 3'd3;
  localparam reg_idx_t REG_RECT_W         = 3'd4;
  localparam reg_idx_t REG_RECT_H         = 3'd5;
  localparam reg_idx_t REG_LINE_THICKNESS = 3'd6;
  localparam reg_idx_t REG_FILL_COLOUR    = 3'd7;

  typedef logic signed [GEO_W-1:0] geo_val_t;

  // signed zero so geometry compares stay signed
  localparam geo_val_t GEO_ZERO = geo_val_t'(0);
  localparam geo_val_t MIN_DIM = geo_val_t'(2);
  localparam geo_val_t MAX_DIM = geo_val_t'(64'd1 << COORD_BITS);

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [11:0] rect_left;
    logic [11:0] rect_top;
    logic [12:0] rect_w;
    logic [12:0] rect_h;
    logic [7:0]  line_thickness;
    logic [23:0] fill_colour;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:    13'd1920,
    frame_height:   13'd1080,
    rect_left:      12'd0,
    rect_top:       12'd0,
    rect_w:         13'd0,
    rect_h:         13'd0,
    line_thickness: 8'd2,
    fill_colour:    24'h963501
  };

  // one band as half-open ranges, live when both sizes are positive
  typedef struct packed {
    geo_val_t bx0;
    geo_val_t bx1;
    geo_val_t by0;
    geo_val_t by1;
    logic     live;
  } band_t;

  typedef struct packed {
    geo_val_t     wd;
    geo_val_t     ht;
    band_t [3:0]  bands;
  } geo_t;

  // one accepted beat with its frame position
  typedef struct packed {
    logic [7:0]            pixel;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic                  chroma;
    logic                  fend;
  } pos_t;

  // one result beat
  typedef struct packed {
    logic [7:0] pixel;
    logic       hit;
    logic       fend;
  } res_t;

  // frame dimension limited to 2 .. 2^COORD_BITS
  function automatic geo_val_t clamp_dim(input logic [12:0] v);
    geo_val_t d;
    d = geo_val_t'(v);
    if (d < MIN_DIM) d = MIN_DIM;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

endpackage

[rtl/core/nro_cfg_regs.sv]
// nro_cfg_regs: apb register file holding the overlay configuration
// depends on nro_pkg
`timescale 1ns / 1ps

module nro_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nro_pkg::ADDR_W-1:0] paddr,
  input  logic [nro_pkg::DATA_W-1:0] pwdata,
  output logic [nro_pkg::DATA_W-1:0] prdata,
  output nro_pkg::cfg_t              cfg
);

  nro_pkg::cfg_t     cfg_r;
  nro_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = nro_pkg::reg_idx_t'(paddr[nro_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= nro_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        nro_pkg::REG_FRAME_WIDTH:    cfg_r.frame_width    <= pwdata[12:0];
        nro_pkg::REG_FRAME_HEIGHT:   cfg_r.frame_height   <= pwdata[12:0];
        nro_pkg::REG_RECT_LEFT:      cfg_r.rect_left      <= pwdata[11:0];
        nro_pkg::REG_RECT_TOP:       cfg_r.rect_top       <= pwdata[11:0];
        nro_pkg::REG_RECT_W:         cfg_r.rect_w         <= pwdata[12:0];
        nro_pkg::REG_RECT_H:         cfg_r.rect_h         <= pwdata[12:0];
        nro_pkg::REG_LINE_THICKNESS: cfg_r.line_thickness <= pwdata[7:0];
        nro_pkg::REG_FILL_COLOUR:    cfg_r.fill_colour    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      nro_pkg::REG_FRAME_WIDTH:    prdata = nro_pkg::DATA_W'(cfg_r.frame_width);
      nro_pkg::REG_FRAME_HEIGHT:   prdata = nro_pkg::DATA_W'(cfg_r.frame_height);
      nro_pkg::REG_RECT_LEFT:      prdata = nro_pkg::DATA_W'(cfg_r.rect_left);
      nro_pkg::REG_RECT_TOP:       prdata = nro_pkg::DATA_W'(cfg_r.rect_top);
      nro_pkg::REG_RECT_W:         prdata = nro_pkg::DATA_W'(cfg_r.rect_w);
      nro_pkg::REG_RECT_H:         prdata = nro_pkg::DATA_W'(cfg_r.rect_h);
      nro_pkg::REG_LINE_THICKNESS: prdata = nro_pkg::DATA_W'(cfg_r.line_thickness);
      nro_pkg::REG_FILL_COLOUR:    prdata = nro_pkg::DATA_W'(cfg_r.fill_colour);
      default:                     prdata = '0;
    endcase
  end

endmodule

[rtl/core/nro_geom.sv]
// nro_geom: derives the four outline bands from the configuration, registered
// depends on nro_pkg
`timescale 1ns / 1ps

module nro_geom (
  input  logic          clk,
  input  nro_pkg::cfg_t cfg,
  output nro_pkg::geo_t geo
);

  nro_pkg::geo_t     geo_r;
  nro_pkg::geo_t     geo_nxt;
  nro_pkg::geo_val_t wd, ht, x, y, t, rw0, rh0, rw, rh;
  nro_pkg::geo_val_t ly, rx, bot_y, side_h;

  assign geo = geo_r;

  // even origin, size and thickness
  assign wd  = nro_pkg::clamp_dim(cfg.frame_width);
  assign ht  = nro_pkg::clamp_dim(cfg.frame_height);
  assign x   = nro_pkg::geo_val_t'({cfg.rect_left[11:1], 1'b0});
  assign y   = nro_pkg::geo_val_t'({cfg.rect_top[11:1], 1'b0});
  assign t   = nro_pkg::geo_val_t'({cfg.line_thickness[7:1], 1'b0});
  assign rw0 = nro_pkg::geo_val_t'({cfg.rect_w[12:1], 1'b0});
  assign rh0 = nro_pkg::geo_val_t'({cfg.rect_h[12:1], 1'b0});

  // size clipped to the frame, floored at zero
  always_comb begin
    rw = rw0;
    if (rw0 + x >= wd) rw = wd - x;
    if (rw < nro_pkg::GEO_ZERO) rw = nro_pkg::GEO_ZERO;
    rh = rh0;
    if (rh0 + y >= ht) rh = ht - y;
    if (rh < nro_pkg::GEO_ZERO) rh = nro_pkg::GEO_ZERO;
  end

  // band origins
  always_comb begin
    ly     = (y + t < ht) ? (y + t) : (ht - t);
    rx     = (x + rw - t < wd) ? (x + rw - t) : (wd - t);
    bot_y  = (y + rh - t >= nro_pkg::GEO_ZERO) ? (y + rh - t) : nro_pkg::GEO_ZERO;
    side_h = rh - (t <<< 1);
  end

  // bands as half-open ranges: top, bottom, left, right
  always_comb begin
    geo_nxt.wd = wd;
    geo_nxt.ht = ht;
    geo_nxt.bands[0] = '{bx0: x, bx1: x + rw, by0: y, by1: y + t,
                         live: (rw > nro_pkg::GEO_ZERO) && (t > nro_pkg::GEO_ZERO)};
    geo_nxt.bands[1] = '{bx0: x, bx1: x + rw, by0: bot_y, by1: bot_y + t,
                         live: (rw > nro_pkg::GEO_ZERO) && (t > nro_pkg::GEO_ZERO)};
    geo_nxt.bands[2] = '{bx0: x, bx1: x + t, by0: ly, by1: ly + side_h,
                         live: (t > nro_pkg::GEO_ZERO) && (side_h > nro_pkg::GEO_ZERO)};
    geo_nxt.bands[3] = '{bx0: rx, bx1: rx + t, by0: ly, by1: ly + side_h,
                         live: (t > nro_pkg::GEO_ZERO) && (side_h > nro_pkg::GEO_ZERO)};
  end

  always_ff @(posedge clk) begin
    geo_r <= geo_nxt;
  end

endmodule

[rtl/core/nro_pos_track.sv]
// nro_pos_track: input stage with row, column and plane counters
// depends on nro_pkg
`timescale 1ns / 1ps

module nro_pos_track (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    pixel_in,
  input  logic          frame_start,
  input  nro_pkg::cfg_t cfg,
  input  logic          hit_ready,
  output logic          s1_valid,
  output nro_pkg::pos_t s1
);

  logic [nro_pkg::COORD_BITS-1:0] row_r, col_r, row_nxt, col_nxt, row_cur, col_cur;
  logic                           chroma_r, chroma_nxt, chroma_cur;
  logic                           s1_valid_r;
  nro_pkg::pos_t                  s1_r, s1_nxt;
  nro_pkg::geo_val_t              wd, ht, plane_rows;
  logic                           last_col, last_row, acc;

  assign in_ready = !s1_valid_r || hit_ready;
  assign acc      = in_valid && in_ready;
  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  // position of this beat, restarted by frame_start
  assign row_cur    = frame_start ? '0 : row_r;
  assign col_cur    = frame_start ? '0 : col_r;
  assign chroma_cur = frame_start ? 1'b0 : chroma_r;

  // end of row and end of plane
  assign wd         = nro_pkg::clamp_dim(cfg.frame_width);
  assign ht         = nro_pkg::clamp_dim(cfg.frame_height);
  assign plane_rows = chroma_cur ? (ht >>> 1) : ht;
  assign last_col   = (nro_pkg::geo_val_t'(col_cur) + nro_pkg::geo_val_t'(1) >= wd);
  assign last_row   = (nro_pkg::geo_val_t'(row_cur) + nro_pkg::geo_val_t'(1) >= plane_rows);

  // counter advance
  always_comb begin
    row_nxt    = row_cur;
    col_nxt    = col_cur + 1'b1;
    chroma_nxt = chroma_cur;
    if (last_col) begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt    = '0;
        chroma_nxt = !chroma_cur;
      end else begin
        row_nxt = row_cur + 1'b1;
      end
    end
  end

  assign s1_nxt = '{pixel: pixel_in, row: row_cur, col: col_cur, chroma: chroma_cur,
                    fend: chroma_cur && last_col && last_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      chroma_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        chroma_r <= chroma_nxt;
      end
      if (in_ready) s1_valid_r <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (acc) s1_r <= s1_nxt;
  end

`ifndef SYNTHESIS
  // a frame start beat always sits at the first luma byte
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && frame_start |=> s1_r.row == '0 && s1_r.col == '0 && !s1_r.chroma)
    else $error("frame start did not restart the position");

  // frame end only flagged in the chroma plane
  a_fend_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.fend |-> s1_r.chroma)
    else $error("frame end outside the chroma plane");
`endif

endmodule

[rtl/core/nro_outline_hit.sv]
// nro_outline_hit: band test, colour pick and result register
// depends on nro_pkg
`timescale 1ns / 1ps

module nro_outline_hit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  output logic          hit_ready,
  input  nro_pkg::pos_t s1,
  input  nro_pkg::geo_t geo,
  input  logic [23:0]   fill_colour,
  input  logic          out_ready,
  output logic          out_valid,
  output nro_pkg::res_t res
);

  logic              out_valid_r;
  nro_pkg::res_t     out_r, out_nxt;
  nro_pkg::geo_val_t r, c;
  logic [3:0]        band_hit;
  logic              in_frame, hit;
  logic [7:0]        colour;

  assign hit_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign res       = out_r;

  // luma position of this byte; chroma maps to luma row 2*row at the even column
  assign r = s1.chroma ? nro_pkg::geo_val_t'({s1.row, 1'b0}) : nro_pkg::geo_val_t'(s1.row);
  assign c = s1.chroma ? nro_pkg::geo_val_t'({s1.col[nro_pkg::COORD_BITS-1:1], 1'b0})
                       : nro_pkg::geo_val_t'(s1.col);

  assign in_frame = (r < geo.ht) && (c < geo.wd);

  // one compare set per band
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      band_hit[i] = geo.bands[i].live &&
                    (r >= geo.bands[i].by0) && (r < geo.bands[i].by1) &&
                    (c >= geo.bands[i].bx0) && (c < geo.bands[i].bx1);
    end
  end

  assign hit = in_frame && (|band_hit);

  // y for luma, v on even chroma bytes, u on odd ones
  assign colour = !s1.chroma ? fill_colour[23:16] :
                  (s1.col[0] ? fill_colour[15:8] : fill_colour[7:0]);

  assign out_nxt = '{pixel: hit ? colour : s1.pixel, hit: hit, fend: s1.fend};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (hit_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_ready && s1_valid) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // a replaced byte carries one of the three fill components
  a_hit_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.hit |-> out_r.pixel == fill_colour[23:16] ||
      out_r.pixel == fill_colour[15:8] || out_r.pixel == fill_colour[7:0])
    else $error("replaced byte is not a fill component");

  // a live top band never has an empty range
  a_band_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    geo.bands[0].live |-> geo.bands[0].bx1 > geo.bands[0].bx0 &&
      geo.bands[0].by1 > geo.bands[0].by0)
    else $error("live top band has an empty range");
`endif

endmodule

[rtl/core/nv21_rect_outline_overlay_core.sv]
// nv21_rect_outline_overlay_core: top level of the nv21 rectangle outline overlay
// path: an accepted beat passes the input register, then the result register
// throughput: one byte per cycle while out_ready is high, set by the input and result registers
// reset: rst_n synchronous active low; counters to first luma byte, registers to defaults
// depends on nro_pkg, nro_cfg_regs, nro_geom, nro_pos_track, nro_outline_hit
`timescale 1ns / 1ps

module nv21_rect_outline_overlay_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_pixel_in,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_pixel_out,
  output logic                       out_on_outline,
  output logic                       out_frame_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nro_pkg::ADDR_W-1:0] paddr,
  input  logic [nro_pkg::DATA_W-1:0] pwdata,
  output logic [nro_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  nro_pkg::cfg_t cfg;
  nro_pkg::geo_t geo;
  nro_pkg::pos_t s1;
  nro_pkg::res_t res;
  logic          s1_valid, hit_ready;

  assign pready = 1'b1;

  // configuration registers
  nro_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // band geometry
  nro_geom u_geom (
    .clk (clk),
    .cfg (cfg),
    .geo (geo)
  );

  // position tracking and input register
  nro_pos_track u_pos_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_in    (in_pixel_in),
    .frame_start (in_frame_start),
    .cfg         (cfg),
    .hit_ready   (hit_ready),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  // outline test and result register
  nro_outline_hit u_outline_hit (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .hit_ready   (hit_ready),
    .s1          (s1),
    .geo         (geo),
    .fill_colour (cfg.fill_colour),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .res         (res)
  );

  assign out_pixel_out  = res.pixel;
  assign out_on_outline = res.hit;
  assign out_frame_end  = res.fend;

endmodule

[bench/tb_nv21_rect_outline_overlay_core.sv]
// tb_nv21_rect_outline_overlay_core: self-checking bench for the nv21 outline overlay core
// drives byte beats and apb register writes, predicts every result beat and compares in order
// depends on nro_pkg and nv21_rect_outline_overlay_core
`timescale 1ns / 1ps

module tb_nv21_rect_outline_overlay_core;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_BEATS   = 600;
  localparam int LEAD_BEATS   = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // one predicted result beat
  typedef struct packed {
    logic [7:0] pixel;
    logic       hit;
    logic       fend;
  } overlay_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_pixel_in = 8'h00;
  logic                       in_frame_start = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [7:0]                 out_pixel_out;
  logic                       out_on_outline;
  logic                       out_frame_end;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [nro_pkg::ADDR_W-1:0] paddr = '0;
  logic [nro_pkg::DATA_W-1:0] pwdata = '0;
  logic [nro_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // bench state
  nro_pkg::cfg_t                  shadow_cfg;
  logic [nro_pkg::COORD_BITS-1:0] col_pos;
  logic [nro_pkg::COORD_BITS-1:0] row_pos;
  logic                           chroma_plane;
  overlay_beat_t                  pending_overlay[$];

  int  mismatch_cnt = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  hits_seen = 0;
  int  fends_seen = 0;
  int  reg_writes = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_gaps_on = 1'b1;
  logic hold_req = 1'b0;

  nv21_rect_outline_overlay_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_on_outline (out_on_outline),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // frame dimension limited to 2 .. 2^COORD_BITS
  function automatic longint limit_dim(input logic [12:0] v);
    longint d;
    d = v;
    if (d < 2) d = 2;
    if (d > (longint'(1) << nro_pkg::COORD_BITS)) d = longint'(1) << nro_pkg::COORD_BITS;
    return d;
  endfunction

  // bytes in one full frame under the current sizes
  function automatic int frame_bytes();
    longint wd, ht;
    wd = limit_dim(shadow_cfg.frame_width);
    ht = limit_dim(shadow_cfg.frame_height);
    return int'(wd * ht + wd * (ht / 2));
  endfunction

  // luma position inside one of the four outline bands
  function automatic bit in_outline(input longint wd, input longint ht,
                                    input longint r, input longint c);
    longint x, y, t, rw, rh, ly, rx;
    longint bx[4];
    longint by[4];
    longint bw[4];
    longint bh[4];
    if (r < 0 || r >= ht || c < 0 || c >= wd) return 1'b0;
    x  = {shadow_cfg.rect_left[11:1], 1'b0};
    y  = {shadow_cfg.rect_top[11:1], 1'b0};
    t  = {shadow_cfg.line_thickness[7:1], 1'b0};
    rw = {shadow_cfg.rect_w[12:1], 1'b0};
    rh = {shadow_cfg.rect_h[12:1], 1'b0};
    if (rw + x >= wd) rw = wd - x;
    if (rw < 0) rw = 0;
    if (rh + y >= ht) rh = ht - y;
    if (rh < 0) rh = 0;
    ly = (y + t < ht) ? y + t : ht - t;
    rx = (x + rw - t < wd) ? x + rw - t : wd - t;
    bx = '{x, x, x, rx};
    by = '{y, ((y + rh - t >= 0) ? y + rh - t : 0), ly, ly};
    bw = '{rw, rw, t, t};
    bh = '{t, t, rh - 2 * t, rh - 2 * t};
    for (int i = 0; i < 4; i++) begin
      if (bw[i] > 0 && bh[i] > 0 && r >= by[i] && r < by[i] + bh[i] &&
          c >= bx[i] && c < bx[i] + bw[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the frame position by one accepted byte and queue its result
  task automatic predict_overlay_byte(input logic [7:0] pix, input logic fstart);
    longint wd, ht, rows, r, c;
    bit hit, last_c, last_r;
    logic [7:0] fill;
    overlay_beat_t e;
    wd = limit_dim(shadow_cfg.frame_width);
    ht = limit_dim(shadow_cfg.frame_height);
    if (fstart) begin
      col_pos = '0;
      row_pos = '0;
      chroma_plane = 1'b0;
    end
    r = row_pos;
    c = col_pos;
    if (!chroma_plane) begin
      hit  = in_outline(wd, ht, r, c);
      fill = shadow_cfg.fill_colour[23:16];
      rows = ht;
    end else begin
      hit  = in_outline(wd, ht, 2 * r, (c >> 1) << 1);
      fill = c[0] ? shadow_cfg.fill_colour[15:8] : shadow_cfg.fill_colour[7:0];
      rows = ht / 2;
    end
    last_c = (c + 1 >= wd);
    last_r = (r + 1 >= rows);
    e.pixel = hit ? fill : pix;
    e.hit   = hit;
    e.fend  = chroma_plane && last_c && last_r;
    if (last_c) begin
      col_pos = '0;
      if (last_r) begin
        row_pos = '0;
        chroma_plane = !chroma_plane;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    pending_overlay.push_back(e);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // apb write: setup cycle, then access cycle until pready
  task automatic cfg_write(input nro_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      nro_pkg::REG_FRAME_WIDTH:    shadow_cfg.frame_width    = val[12:0];
      nro_pkg::REG_FRAME_HEIGHT:   shadow_cfg.frame_height   = val[12:0];
      nro_pkg::REG_RECT_LEFT:      shadow_cfg.rect_left      = val[11:0];
      nro_pkg::REG_RECT_TOP:       shadow_cfg.rect_top       = val[11:0];
      nro_pkg::REG_RECT_W:         shadow_cfg.rect_w         = val[12:0];
      nro_pkg::REG_RECT_H:         shadow_cfg.rect_h         = val[12:0];
      nro_pkg::REG_LINE_THICKNESS: shadow_cfg.line_thickness = val[7:0];
      nro_pkg::REG_FILL_COLOUR:    shadow_cfg.fill_colour    = val[23:0];
      default: ;
    endcase
  endtask

  // write every register in one go
  task automatic cfg_all(input int fw, input int fh, input int rl, input int rt,
                         input int rw, input int rh, input int th, input int col);
    cfg_write(nro_pkg::REG_FRAME_WIDTH, fw);
    cfg_write(nro_pkg::REG_FRAME_HEIGHT, fh);
    cfg_write(nro_pkg::REG_RECT_LEFT, rl);
    cfg_write(nro_pkg::REG_RECT_TOP, rt);
    cfg_write(nro_pkg::REG_RECT_W, rw);
    cfg_write(nro_pkg::REG_RECT_H, rh);
    cfg_write(nro_pkg::REG_LINE_THICKNESS, th);
    cfg_write(nro_pkg::REG_FILL_COLOUR, col);
  endtask

  // offer one byte beat, hold it until taken, then maybe idle
  task automatic send_beat(input logic [7:0] pix, input logic fstart);
    int g;
    in_valid       <= 1'b1;
    in_pixel_in    <= pix;
    in_frame_start <= fstart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_overlay_byte(pix, fstart);
    beats_in++;
    g = in_gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // a run of random bytes, first one optionally marking frame start, later ones now and then when noisy
  task automatic send_frame(input bit with_start, input int n, input bit noisy);
    logic fs;
    for (int i = 0; i < n; i++) begin
      fs = (i == 0) ? with_start : (noisy && $urandom_range(0, 19) == 0);
      send_beat(8'($urandom_range(0, 255)), fs);
    end
  endtask

  // stop offering, let every result drain and the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_overlay.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // bytes under reset defaults: no rectangle, nothing replaced
  task automatic test_reset_defaults();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'hA5, 1'b0);
    wait_idle();
  endtask

  // small full frame with odd requests rounded down and clipped
  task automatic test_small_outline();
    cfg_all(6, 2, 3, 1, 3, 9, 3, 24'hFFFFFF);
    send_frame(1'b1, frame_bytes(), 1'b0);
    wait_idle();
  endtask

  // register extremes: sizes clamped, rectangle far out of frame
  task automatic test_register_extremes();
    cfg_all(0, 8191, 4095, 4095, 8191, 8191, 255, 0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h80, 1'b0);
    wait_idle();
  endtask

  // widest and tallest frames, leading bytes of each
  task automatic test_large_frames();
    in_gaps_on = 1'b0;
    cfg_all(4096, 2, 40, 0, 8191, 2, 254, $urandom & 24'hFFFFFF);
    send_frame(1'b1, LEAD_BEATS, 1'b0);
    wait_idle();
    cfg_all(2, 4096, 0, 20, 2, 8191, 100, $urandom & 24'hFFFFFF);
    send_frame(1'b1, LEAD_BEATS, 1'b0);
    wait_idle();
    in_gaps_on = 1'b1;
  endtask

  // sizes changed with the counters mid-frame, then frames with no start marker
  task automatic test_resize_midframe();
    cfg_all(8, 4, 0, 0, 8, 4, 2, $urandom & 24'hFFFFFF);
    send_frame(1'b1, 21, 1'b0);
    wait_idle();
    cfg_write(nro_pkg::REG_FRAME_WIDTH, 4);
    send_frame(1'b0, 10, 1'b0);
    wait_idle();
    cfg_write(nro_pkg::REG_FRAME_HEIGHT, 2);
    send_frame(1'b0, 30, 1'b0);
    wait_idle();
    cfg_write(nro_pkg::REG_FRAME_HEIGHT, 5);
    send_frame(1'b0, 2 * frame_bytes() + 3, 1'b0);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    cfg_all(10, 6, 2, 2, 6, 4, 2, $urandom & 24'hFFFFFF);
    in_gaps_on = 1'b0;
    hold_req <= 1'b1;
    send_frame(1'b1, 200, 1'b0);
    hold_req <= 1'b0;
    in_gaps_on = 1'b1;
    wait_idle();
  endtask

  // random small geometry, now and then a far out value
  task automatic random_config();
    int fw, fh, p;
    p = $urandom_range(0, 15);
    fw = (p == 0) ? $urandom_range(0, 1) :
         (p == 1) ? ($urandom_range(3, 15) | 1) : 2 * $urandom_range(1, 8);
    p = $urandom_range(0, 15);
    fh = (p == 0) ? $urandom_range(0, 1) :
         (p == 1) ? ($urandom_range(3, 9) | 1) : 2 * $urandom_range(1, 5);
    cfg_write(nro_pkg::REG_FRAME_WIDTH, fw);
    cfg_write(nro_pkg::REG_FRAME_HEIGHT, fh);
    cfg_write(nro_pkg::REG_RECT_LEFT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
                                                                   $urandom_range(0, fw + 2));
    cfg_write(nro_pkg::REG_RECT_TOP, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
                                                                  $urandom_range(0, fh + 2));
    cfg_write(nro_pkg::REG_RECT_W, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                                                                $urandom_range(0, fw + 4));
    cfg_write(nro_pkg::REG_RECT_H, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) :
                                                                $urandom_range(0, fh + 4));
    cfg_write(nro_pkg::REG_LINE_THICKNESS,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
    cfg_write(nro_pkg::REG_FILL_COLOUR, $urandom & 24'hFFFFFF);
  endtask

  // mostly whole frames with random content, some unmarked, some cut short and noisy
  task automatic test_random_frames();
    int start_cnt, k;
    start_cnt = beats_in;
    random_config();
    while (beats_in - start_cnt < RAND_BEATS) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        random_config();
      end
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      k = $urandom_range(0, 9);
      if (k < 8) send_frame(1'b1, frame_bytes(), 1'b0);
      else if (k == 8) send_frame(1'b0, frame_bytes(), 1'b0);
      else send_frame(1'($urandom_range(0, 1)), $urandom_range(1, frame_bytes()), 1'b1);
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    wait_idle();
  endtask

  // compare one result beat against the oldest prediction
  task automatic check_result();
    overlay_beat_t e;
    beats_out++;
    if (pending_overlay.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("result beat %0d with nothing expected: pixel %02h outline %0b end %0b",
                 beats_out, out_pixel_out, out_on_outline, out_frame_end);
    end else begin
      e = pending_overlay.pop_front();
      hits_seen  += e.hit;
      fends_seen += e.fend;
      if (out_pixel_out !== e.pixel || out_on_outline !== e.hit ||
          out_frame_end !== e.fend) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("result beat %0d: expected pixel %02h outline %0b end %0b, got %02h %0b %0b",
                   beats_out, e.pixel, e.hit, e.fend,
                   out_pixel_out, out_on_outline, out_frame_end);
      end
    end
  endtask

  // receiver: check taken beats, then pick next ready with random stalls
  initial begin
    int stall_left;
    bit hold_seen;
    stall_left = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result();
      if (hold_req && !hold_seen) begin
        hold_seen  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (!hold_req) hold_seen = 1'b0;
      if (stall_left == 0 && out_gaps_on) stall_left = gap_len();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no beat and no register access
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d results still due",
                 QUIET_LIMIT, pending_overlay.size());
        $display("nv21_rect_outline_overlay_core: mismatch");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    shadow_cfg.frame_width    = 13'd1920;
    shadow_cfg.frame_height   = 13'd1080;
    shadow_cfg.rect_left      = 12'd0;
    shadow_cfg.rect_top       = 12'd0;
    shadow_cfg.rect_w         = 13'd0;
    shadow_cfg.rect_h         = 13'd0;
    shadow_cfg.line_thickness = 8'd2;
    shadow_cfg.fill_colour    = 24'h963501;
    col_pos      = '0;
    row_pos      = '0;
    chroma_plane = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_small_outline();
    test_register_extremes();
    test_large_frames();
    test_resize_midframe();
    test_backpressure();
    test_random_frames();

    // drain, then wait DRAIN_CYCLES for stray beats
    while (pending_overlay.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d byte beats in, %0d results checked, %0d register writes",
             beats_in, beats_out, reg_writes);
    $display("covered: %0d outline bytes, %0d frame ends, %0d mismatches",
             hits_seen, fends_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_overlay.size() == 0) begin
      $display("nv21_rect_outline_overlay_core: match");
    end else begin
      $display("nv21_rect_outline_overlay_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/nro_pkg.sv
rtl/core/nro_cfg_regs.sv
rtl/core/nro_geom.sv
rtl/core/nro_pos_track.sv
rtl/core/nro_outline_hit.sv
rtl/core/nv21_rect_outline_overlay_core.sv
bench/tb_nv21_rect_outline_overlay_core.sv
